// File: hdl/stmm_pkg.sv
// Shared types and operation codes for the sparse triplet multiplier.
`timescale 1ns / 1ps
package stmm_pkg;
	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_MULTIPLY = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	localparam int unsigned OUT_VALUE_BITS = 40;
	localparam int unsigned DIM_BITS = 9;

	localparam logic [1:0] REG_A_COLUMNS = 2'd0;
	localparam logic [1:0] REG_B_ROWS = 2'd1;
	localparam logic [1:0] REG_B_COLUMNS = 2'd2;
endpackage

// File: hdl/stmm_regs.sv
// APB register file for the matrix dimensions.
`timescale 1ns / 1ps
module stmm_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [stmm_pkg::DIM_BITS-1:0] a_columns,
	output logic [stmm_pkg::DIM_BITS-1:0] b_rows,
	output logic [stmm_pkg::DIM_BITS-1:0] b_columns
);
	logic [stmm_pkg::DIM_BITS-1:0] a_columns_q, b_rows_q, b_columns_q;
	logic [1:0] idx;

	assign idx = paddr[3:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_columns_q <= 9'd1;
			b_rows_q <= 9'd1;
			b_columns_q <= 9'd1;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				stmm_pkg::REG_A_COLUMNS: a_columns_q <= pwdata[8:0];
				stmm_pkg::REG_B_ROWS: b_rows_q <= pwdata[8:0];
				stmm_pkg::REG_B_COLUMNS: b_columns_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			stmm_pkg::REG_A_COLUMNS: prdata = {23'd0, a_columns_q};
			stmm_pkg::REG_B_ROWS: prdata = {23'd0, b_rows_q};
			stmm_pkg::REG_B_COLUMNS: prdata = {23'd0, b_columns_q};
			default: prdata = '0;
		endcase
	end

	assign a_columns = a_columns_q;
	assign b_rows = b_rows_q;
	assign b_columns = b_columns_q;
endmodule

// File: hdl/stmm_engine.sv
// Sequencer with stores, one shared multiplier and the product list.
`timescale 1ns / 1ps
module stmm_engine #(
	parameter int unsigned MAX_NONZEROS = 8,
	parameter int unsigned INDEX_BITS = 8,
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [stmm_pkg::DIM_BITS-1:0] a_columns,
	input  logic [stmm_pkg::DIM_BITS-1:0] b_rows,
	input  logic [stmm_pkg::DIM_BITS-1:0] b_columns,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] row,
	input  logic [7:0] col,
	input  logic signed [15:0] value,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_row,
	output logic [7:0] out_col,
	output logic signed [stmm_pkg::OUT_VALUE_BITS-1:0] out_value,
	output logic is_entry,
	output logic mismatch,
	output logic last
);
	localparam int unsigned NB = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
	localparam int unsigned CB = $clog2(MAX_NONZEROS + 1);
	localparam int unsigned PMAX = MAX_NONZEROS * MAX_NONZEROS;
	localparam int unsigned PB = (PMAX > 1) ? $clog2(PMAX) : 1;
	localparam int unsigned PCB = $clog2(PMAX + 1);
	localparam int unsigned OVB = stmm_pkg::OUT_VALUE_BITS;

	typedef struct packed {
		logic [INDEX_BITS-1:0] r;
		logic [INDEX_BITS-1:0] c;
		logic signed [VALUE_BITS-1:0] v;
	} trip_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SORT, S_PAIR, S_MUL, S_SCAN, S_RD, S_ADD, S_EMIT_RD, S_EMIT, S_ONE
	} state_t;

	state_t state_q;
	trip_t a_q [MAX_NONZEROS];
	trip_t b_q [MAX_NONZEROS];
	trip_t ord_q [MAX_NONZEROS];
	logic [CB-1:0] a_cnt_q, b_cnt_q, n_ord_q;
	logic [INDEX_BITS:0] sc_q;        // column being gathered
	logic [CB-1:0] j_q, i_q;
	logic [INDEX_BITS-1:0] pr_q, pc_q;
	logic signed [2*VALUE_BITS-1:0] prod_q;
	// product list memory
	logic [INDEX_BITS-1:0] pl_row [PMAX];
	logic [INDEX_BITS-1:0] pl_col [PMAX];
	logic [OVB-1:0] pl_sum [PMAX];
	logic [PCB-1:0] pcnt_q, k_q;
	logic [OVB-1:0] rd_sum_q;
	logic [INDEX_BITS-1:0] rd_row_q, rd_col_q;
	logic [7:0] o_row_q, o_col_q;
	logic [OVB-1:0] o_val_q;
	logic o_ent_q, o_mis_q, o_last_q, o_vld_q;

	trip_t t_in;
	assign t_in = '{r: row[INDEX_BITS-1:0], c: col[INDEX_BITS-1:0], v: value[VALUE_BITS-1:0]};
	assign in_ready = (state_q == S_IDLE) && !o_vld_q;

	trip_t a_cur, b_cur, o_cur;
	assign a_cur = a_q[i_q[NB-1:0]];
	assign b_cur = b_q[j_q[NB-1:0]];
	assign o_cur = ord_q[j_q[NB-1:0]];

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready) begin
			if (operation == stmm_pkg::OP_LOAD_A && a_cnt_q < CB'(MAX_NONZEROS))
				a_q[a_cnt_q[NB-1:0]] <= t_in;
			if (operation == stmm_pkg::OP_LOAD_B && b_cnt_q < CB'(MAX_NONZEROS))
				b_q[b_cnt_q[NB-1:0]] <= t_in;
		end
		if (state_q == S_SORT && j_q < b_cnt_q && {1'b0, b_cur.c} == sc_q
			&& n_ord_q < CB'(MAX_NONZEROS))
			ord_q[n_ord_q[NB-1:0]] <= b_cur;
		if (state_q == S_PAIR) begin
			prod_q <= a_cur.v * o_cur.v;
			pr_q <= a_cur.r;
			pc_q <= o_cur.c;
		end
		// single write port on the product list
		if (state_q == S_ADD) begin
			if (k_q == pcnt_q) begin
				pl_row[k_q[PB-1:0]] <= pr_q;
				pl_col[k_q[PB-1:0]] <= pc_q;
				pl_sum[k_q[PB-1:0]] <= OVB'(prod_q);
			end else
				pl_sum[k_q[PB-1:0]] <= rd_sum_q + OVB'(prod_q);
		end
		if (k_q < PCB'(PMAX)) begin
			rd_sum_q <= pl_sum[k_q[PB-1:0]];
			rd_row_q <= pl_row[k_q[PB-1:0]];
			rd_col_q <= pl_col[k_q[PB-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			a_cnt_q <= '0; b_cnt_q <= '0; n_ord_q <= '0;
			sc_q <= '0; j_q <= '0; i_q <= '0; pcnt_q <= '0; k_q <= '0;
			o_vld_q <= 1'b0; o_row_q <= '0; o_col_q <= '0; o_val_q <= '0;
			o_ent_q <= 1'b0; o_mis_q <= 1'b0; o_last_q <= 1'b0;
		end else begin
			if (o_vld_q && out_ready) o_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					unique case (operation)
						stmm_pkg::OP_LOAD_A:
							if (a_cnt_q < CB'(MAX_NONZEROS)) a_cnt_q <= a_cnt_q + 1'b1;
						stmm_pkg::OP_LOAD_B:
							if (b_cnt_q < CB'(MAX_NONZEROS)) b_cnt_q <= b_cnt_q + 1'b1;
						stmm_pkg::OP_MULTIPLY: begin
							if (a_columns != b_rows) begin
								a_cnt_q <= '0; b_cnt_q <= '0;
								o_row_q <= '0; o_col_q <= '0; o_val_q <= '0;
								o_ent_q <= 1'b0; o_mis_q <= 1'b1; o_last_q <= 1'b1;
								o_vld_q <= 1'b1;
							end else begin
								sc_q <= '0; j_q <= '0; n_ord_q <= '0;
								state_q <= S_SORT;
							end
						end
						default: ;
					endcase
				end
				// one B entry per cycle for each column below b_columns
				S_SORT: begin
					if (sc_q >= (INDEX_BITS+1)'(1 << INDEX_BITS)
						|| 9'(sc_q) >= b_columns
						|| b_cnt_q == '0) begin
						i_q <= '0; j_q <= '0; pcnt_q <= '0;
						state_q <= S_PAIR;
					end else begin
						if (j_q < b_cnt_q && {1'b0, b_cur.c} == sc_q
							&& n_ord_q < CB'(MAX_NONZEROS))
							n_ord_q <= n_ord_q + 1'b1;
						if (j_q + 1'b1 >= b_cnt_q) begin
							j_q <= '0;
							sc_q <= sc_q + 1'b1;
						end else
							j_q <= j_q + 1'b1;
					end
				end
				S_PAIR: begin
					if (i_q >= a_cnt_q || n_ord_q == '0) begin
						a_cnt_q <= '0; b_cnt_q <= '0; k_q <= '0;
						state_q <= (pcnt_q == '0) ? S_ONE : S_EMIT_RD;
					end else if ({1'b0, a_cur.c} == {1'b0, o_cur.r}) begin
						k_q <= '0;
						state_q <= S_MUL;
					end else
						state_q <= S_MUL;
				end
				S_MUL: begin
					if ({1'b0, a_cur.c} == {1'b0, o_cur.r}) begin
						k_q <= '0;
						state_q <= S_SCAN;
					end else
						state_q <= S_SCAN;
				end
				// walk the list through S_SCAN and S_RD, looking for a match
				S_SCAN: begin
					if ({1'b0, a_cur.c} != {1'b0, o_cur.r}) begin
						state_q <= S_RD;
						k_q <= PCB'(PMAX);
					end else if (k_q == pcnt_q) state_q <= S_ADD;
					else state_q <= S_RD;
				end
				S_RD: begin
					if (k_q == PCB'(PMAX)) begin
						if (j_q + 1'b1 >= n_ord_q) begin
							j_q <= '0; i_q <= i_q + 1'b1;
						end else j_q <= j_q + 1'b1;
						state_q <= S_PAIR;
					end else if (rd_row_q == pr_q && rd_col_q == pc_q)
						state_q <= S_ADD;
					else begin
						k_q <= k_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_ADD: begin
					if (k_q == pcnt_q) pcnt_q <= pcnt_q + 1'b1;
					k_q <= PCB'(PMAX);
					state_q <= S_RD;
				end
				S_EMIT_RD: state_q <= S_EMIT;
				S_EMIT: if (!o_vld_q) begin
					o_row_q <= 8'(rd_row_q); o_col_q <= 8'(rd_col_q);
					o_val_q <= rd_sum_q; o_ent_q <= 1'b1; o_mis_q <= 1'b0;
					o_last_q <= (k_q + 1'b1 == pcnt_q);
					o_vld_q <= 1'b1;
					if (k_q + 1'b1 == pcnt_q) begin
						k_q <= '0; state_q <= S_IDLE;
					end else begin
						k_q <= k_q + 1'b1; state_q <= S_EMIT_RD;
					end
				end
				S_ONE: if (!o_vld_q) begin
					o_row_q <= '0; o_col_q <= '0; o_val_q <= '0;
					o_ent_q <= 1'b0; o_mis_q <= 1'b0; o_last_q <= 1'b1;
					o_vld_q <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = o_vld_q;
	assign out_row = o_row_q;
	assign out_col = o_col_q;
	assign out_value = o_val_q;
	assign is_entry = o_ent_q;
	assign mismatch = o_mis_q;
	assign last = o_last_q;
endmodule

// File: hdl/sparse_triplet_matrix_multiply.sv
// Top level: sparse triplet matrix multiplier.
//  channel | direction | handshake            | payload
//  in      | sink      | in_valid / in_ready  | operation, row, col, value
//  out     | source    | out_valid / out_ready| out_row, out_col, out_value, flags
//  apb     | sink      | psel/penable/pready  | paddr, pwdata, prdata
// A multiply gathers B by column, one B entry a cycle per column below b_columns,
// then takes each A/B pair through S_PAIR, S_MUL and S_SCAN, walks the product
// list through S_SCAN and S_RD and adds in S_ADD where the indices meet; each
// result is read in S_EMIT_RD and sent from S_EMIT, which waits out output stalls.
// Reset clears counts and control; stores hold undefined data until loaded.
`timescale 1ns / 1ps
module sparse_triplet_matrix_multiply #(
	parameter int unsigned MAX_NONZEROS = 8,
	parameter int unsigned INDEX_BITS = 8,
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] row,
	input  logic [7:0] col,
	input  logic signed [15:0] value,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_row,
	output logic [7:0] out_col,
	output logic signed [39:0] out_value,
	output logic is_entry,
	output logic mismatch,
	output logic last
);
	logic [stmm_pkg::DIM_BITS-1:0] a_columns, b_rows, b_columns;

	stmm_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.a_columns, .b_rows, .b_columns
	);

	stmm_engine #(
		.MAX_NONZEROS(MAX_NONZEROS), .INDEX_BITS(INDEX_BITS), .VALUE_BITS(VALUE_BITS)
	) u_engine (
		.clk, .arst_n, .a_columns, .b_rows, .b_columns,
		.in_valid, .in_ready, .operation, .row, .col, .value,
		.out_valid, .out_ready, .out_row, .out_col, .out_value,
		.is_entry, .mismatch, .last
	);
endmodule

// File: hdl/stmm_checker.sv
// Port-level checks for the sparse triplet multiplier.
`timescale 1ns / 1ps
module stmm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic is_entry,
	input logic mismatch,
	input logic last,
	input logic [39:0] out_value
);
	a_mis_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mismatch |-> last && !is_entry) else $error("mismatch not final");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_entry |-> out_value == '0) else $error("empty item not zero");
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind sparse_triplet_matrix_multiply stmm_checker u_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.is_entry, .mismatch, .last, .out_value
);
